FILE: sv/cmlr_pkg.sv
package cmlr_pkg;

  // Fixed widths of the stream fields.
  localparam int SAMPLE_W    = 24;
  localparam int OUT_W       = 16;
  localparam int NUM_SAMPLES = 8;

  // Upper bound on the channel count used for mixing.
  localparam logic [3:0] MAX_SOURCE_CHANNELS = 4'd8;

  // Interpolated results per gap between two frames, and per item overall.
  localparam int MAX_OUTPUTS_PER_FRAME = 16;
  localparam int RESULT_CAP            = 32;
  localparam int COUNT_W               = $clog2(RESULT_CAP + 1);

  // Position arithmetic: Q8.24 step, positions carried on 33 bits.
  localparam int STEP_W = 32;
  localparam int POS_W  = STEP_W + 1;
  localparam int FRAC_W = 24;
  localparam logic [POS_W-1:0] ONE_FRAME = POS_W'(1) << FRAC_W;

  // Register indexes on the configuration channel.
  localparam logic [1:0] CFG_SOURCE_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_POSITION_STEP   = 2'd2;

  localparam logic [1:0] OUT_STEREO = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
    logic signed [SAMPLE_W-1:0] sample_4;
    logic signed [SAMPLE_W-1:0] sample_5;
    logic signed [SAMPLE_W-1:0] sample_6;
    logic signed [SAMPLE_W-1:0] sample_7;
    logic                       last_frame;
  } frame_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_left;
    logic signed [OUT_W-1:0] out_right;
    logic                    last_output;
  } result_t;

  typedef struct packed {
    logic [1:0]        index;
    logic [STEP_W-1:0] value;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic shift;
    logic mul;
    logic sel_right;
    logic acc;
    logic scale;
    logic close_span;
    logic finish;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic stereo;
    logic div_busy;
    logic more;
    logic tail;
    logic last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/cmlr_ifs.sv
interface cmlr_frame_if;
  logic                 valid;
  logic                 ready;
  cmlr_pkg::frame_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmlr_result_if;
  logic                 valid;
  logic                 ready;
  cmlr_pkg::result_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmlr_cfg_if;
  logic                 valid;
  logic                 ready;
  cmlr_pkg::cfg_t       data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cmlr_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module cmlr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [26:0] dividend,
  input  logic [3:0]         divisor,
  output logic               busy,
  output logic signed [23:0] quotient
);

  localparam int STEPS = 27;
  localparam int CNT_W = $clog2(STEPS);

  logic [CNT_W-1:0] cnt;
  logic [26:0]      work;
  logic [3:0]       rem;
  logic [3:0]       dvs;
  logic             neg;
  logic [4:0]       rem_sh;
  logic             ge;
  logic [26:0]      mag;

  assign mag    = dividend[26] ? 27'(-dividend) : 27'(dividend);
  assign rem_sh = {rem, work[26]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEPS - 1);
      work <= mag;
      rem  <= '0;
      dvs  <= divisor;
      neg  <= dividend[26];
    end else if (busy) begin
      rem  <= ge ? 4'(rem_sh - {1'b0, dvs}) : rem_sh[3:0];
      work <= {work[25:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign quotient = neg ? 24'(-work) : work[23:0];

endmodule

FILE: sv/cmlr_dp.sv
// Datapath: configuration registers, mixing, frame history, position
// bookkeeping, the shared interpolation multiplier and the result register.
module cmlr_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  cmlr_pkg::cmd_t         cmd,
  output cmlr_pkg::sts_t         sts,
  input  cmlr_pkg::frame_t       frame,
  input  logic                   cfg_wr,
  input  cmlr_pkg::cfg_t         cfg_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output cmlr_pkg::result_t      res_data
);

  localparam int SW = cmlr_pkg::SAMPLE_W;
  localparam int PW = cmlr_pkg::POS_W;
  localparam int CW = cmlr_pkg::COUNT_W;

  logic [3:0]                  src_ch;
  logic [1:0]                  out_ch;
  logic [cmlr_pkg::STEP_W-1:0] step;

  logic signed [SW-1:0] smp [cmlr_pkg::NUM_SAMPLES];
  logic                 last_q;

  logic signed [SW-1:0] older_l, older_r, newer_l, newer_r;
  logic signed [SW:0]   diff_l, diff_r;
  logic [31:0]          phase;
  logic                 frame_seen;
  logic [PW-1:0]        p;
  logic [CW-1:0]        count;
  logic                 tail;
  logic                 span_en;

  logic signed [SW-1:0] a_q;
  logic signed [49:0]   prod;
  logic signed [49:0]   acc;
  logic signed [15:0]   left_q, right_q;

  logic [3:0]           nch;
  logic                 stereo;
  logic signed [26:0]   sum;
  logic signed [SW-1:0] div_q;
  logic                 div_busy;
  logic signed [SW-1:0] ml, mr;
  logic [PW-1:0]        p_adv, phase_adv, span_phase;
  logic [CW-1:0]        count_adv;
  logic                 next_exists;
  logic [SW-1:0]        f;
  logic signed [SW:0]   d_sel;

  function automatic logic signed [15:0] scale16(input logic signed [49:0] v);
    logic [47:0] mag;
    logic [62:0] scaled;
    logic [15:0] m16;
    if (v >= (50'sd1 <<< 47)) begin
      scale16 = 16'sd32767;
    end else if (v <= -(50'sd1 <<< 47)) begin
      scale16 = -16'sd32767;
    end else begin
      mag     = v[49] ? 48'(-v) : v[47:0];
      scaled  = {mag, 15'b0} - {15'b0, mag};
      m16     = scaled[62:47];
      scale16 = v[49] ? -m16 : m16;
    end
  endfunction

  // Channel count as used for mixing: zero counts as one, and counts above eight are clamped to eight.
  always_comb begin
    if (src_ch == 4'd0) begin
      nch = 4'd1;
    end else if (src_ch > cmlr_pkg::MAX_SOURCE_CHANNELS) begin
      nch = cmlr_pkg::MAX_SOURCE_CHANNELS;
    end else begin
      nch = src_ch;
    end
  end

  assign stereo = (out_ch == cmlr_pkg::OUT_STEREO);

  always_comb begin
    sum = '0;
    for (int c = 0; c < cmlr_pkg::NUM_SAMPLES; c++) begin
      if (4'(c) < nch) begin
        sum = sum + 27'(smp[c]);
      end
    end
  end

  cmlr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (nch),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign ml = stereo ? smp[0] : div_q;
  assign mr = stereo ? ((nch == 4'd1) ? smp[0] : smp[1]) : '0;

  assign span_phase = (p >= cmlr_pkg::ONE_FRAME) ? (p - cmlr_pkg::ONE_FRAME) : '0;

  // Look ahead one position so the final result of an item can be marked.
  assign p_adv     = p + PW'(step);
  assign count_adv = count + 1'b1;
  assign phase_adv = (p_adv >= cmlr_pkg::ONE_FRAME) ? (p_adv - cmlr_pkg::ONE_FRAME) : '0;

  always_comb begin
    if (tail) begin
      next_exists = (p_adv <= cmlr_pkg::ONE_FRAME) && (count_adv < CW'(cmlr_pkg::RESULT_CAP));
    end else begin
      next_exists = ((p_adv < cmlr_pkg::ONE_FRAME) &&
                     (count_adv < CW'(cmlr_pkg::MAX_OUTPUTS_PER_FRAME))) ||
                    (last_q && (phase_adv <= cmlr_pkg::ONE_FRAME) &&
                     (count_adv < CW'(cmlr_pkg::RESULT_CAP)));
    end
  end

  assign f     = tail ? '0 : p[SW-1:0];
  assign d_sel = cmd.sel_right ? diff_r : diff_l;

  always_comb begin
    sts.stereo   = stereo;
    sts.div_busy = div_busy;
    sts.tail     = tail;
    sts.last     = last_q;
    sts.out_free = !res_valid || res_ready;
    if (tail) begin
      sts.more = (p <= cmlr_pkg::ONE_FRAME) && (count < CW'(cmlr_pkg::RESULT_CAP));
    end else begin
      sts.more = span_en && (p < cmlr_pkg::ONE_FRAME) &&
                 (count < CW'(cmlr_pkg::MAX_OUTPUTS_PER_FRAME));
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_ch     <= 4'd1;
      out_ch     <= 2'd1;
      step       <= 32'd16777216;
      frame_seen <= 1'b0;
      phase      <= '0;
      tail       <= 1'b0;
      span_en    <= 1'b0;
      count      <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_data.index)
          cmlr_pkg::CFG_SOURCE_CHANNELS: src_ch <= cfg_data.value[3:0];
          cmlr_pkg::CFG_OUTPUT_CHANNELS: out_ch <= cfg_data.value[1:0];
          cmlr_pkg::CFG_POSITION_STEP:   step   <= cfg_data.value;
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (cmd.shift) begin
        count      <= '0;
        tail       <= 1'b0;
        span_en    <= frame_seen;
        frame_seen <= 1'b1;
        if (!frame_seen) begin
          phase <= '0;
        end
      end
      if (cmd.close_span) begin
        phase <= span_phase[31:0];
        if (last_q) begin
          tail <= 1'b1;
        end
      end
      if (cmd.finish) begin
        frame_seen <= 1'b0;
        phase      <= '0;
      end
      if (cmd.emit) begin
        count     <= count_adv;
        res_valid <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp[0] <= frame.sample_0;
      smp[1] <= frame.sample_1;
      smp[2] <= frame.sample_2;
      smp[3] <= frame.sample_3;
      smp[4] <= frame.sample_4;
      smp[5] <= frame.sample_5;
      smp[6] <= frame.sample_6;
      smp[7] <= frame.sample_7;
      last_q <= frame.last_frame;
    end
    if (cmd.shift) begin
      older_l <= frame_seen ? newer_l : ml;
      older_r <= frame_seen ? newer_r : mr;
      newer_l <= ml;
      newer_r <= mr;
      diff_l  <= (SW+1)'(ml) - (SW+1)'(frame_seen ? newer_l : ml);
      diff_r  <= (SW+1)'(mr) - (SW+1)'(frame_seen ? newer_r : mr);
      p       <= frame_seen ? PW'(phase) : '0;
    end
    if (cmd.close_span && last_q) begin
      p <= span_phase;
    end
    if (cmd.mul) begin
      prod <= 50'(d_sel * $signed({1'b0, f}));
      if (tail) begin
        a_q <= cmd.sel_right ? newer_r : newer_l;
      end else begin
        a_q <= cmd.sel_right ? older_r : older_l;
      end
    end
    if (cmd.acc) begin
      acc <= {{2{a_q[SW-1]}}, a_q, 24'b0} + prod;
    end
    if (cmd.scale) begin
      if (cmd.sel_right) begin
        right_q <= scale16(acc);
      end else begin
        left_q <= scale16(acc);
      end
    end
    if (cmd.emit) begin
      p                    <= p_adv;
      res_data.out_left    <= left_q;
      res_data.out_right   <= stereo ? right_q : '0;
      res_data.last_output <= last_q && !next_exists;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!res_valid || res_ready))
    else $error("result register overwritten before it was taken");

  a_tail_on_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && tail) |-> last_q)
    else $error("end-of-stream result emitted for a frame that is not last");

  a_phase_clear: assert property (@(posedge clk) disable iff (rst)
    !frame_seen |-> (phase == '0))
    else $error("phase left over while no stream is open");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> res_valid)
    else $error("emitted result not presented");
`endif

endmodule

FILE: sv/cmlr_ctrl.sv
// Sequencer: walks one item through mixing, history update and the
// interpolation loop, issuing one datapath command group per cycle.
module cmlr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cmlr_pkg::sts_t  sts,
  output cmlr_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE, MIX, DIV_WAIT, SHIFT, CHECK,
    MUL_L, ACC_L, SCL_L, MUL_R, ACC_R, SCL_R, EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE:     if (in_valid) state <= MIX;
        MIX:      state <= sts.stereo ? SHIFT : DIV_WAIT;
        DIV_WAIT: if (!sts.div_busy) state <= SHIFT;
        SHIFT:    state <= CHECK;
        CHECK: begin
          if (sts.more) begin
            state <= MUL_L;
          end else if (!sts.tail && sts.last) begin
            state <= CHECK;
          end else begin
            state <= IDLE;
          end
        end
        MUL_L:    state <= ACC_L;
        ACC_L:    state <= SCL_L;
        SCL_L:    state <= sts.stereo ? MUL_R : EMIT;
        MUL_R:    state <= ACC_R;
        ACC_R:    state <= SCL_R;
        SCL_R:    state <= EMIT;
        EMIT:     if (sts.out_free) state <= CHECK;
        default:  state <= IDLE;
      endcase
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == IDLE) && in_valid;
    cmd.div_start  = (state == MIX) && !sts.stereo;
    cmd.shift      = (state == SHIFT);
    cmd.mul        = (state == MUL_L) || (state == MUL_R);
    cmd.acc        = (state == ACC_L) || (state == ACC_R);
    cmd.scale      = (state == SCL_L) || (state == SCL_R);
    cmd.sel_right  = (state == MUL_R) || (state == SCL_R);
    cmd.close_span = (state == CHECK) && !sts.more && !sts.tail;
    cmd.finish     = (state == CHECK) && !sts.more && sts.tail;
    cmd.emit       = (state == EMIT) && sts.out_free;
  end

`ifndef SYNTHESIS
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_busy |-> (state == DIV_WAIT))
    else $error("divider running outside its wait state");
`endif

endmodule

FILE: sv/channel_mix_linear_resampler.sv
// Channel     Role      Payload
// frames      in        sample_0..sample_7 (Q1.23), last_frame
// results     out       out_left, out_right, last_output
// cfg         in        index (2 bits), value (32 bits)
//
// An item is accepted, mixed and then written into the frame history. Mono
// mixing adds the serial divider that forms the channel mean. Each result
// then passes through multiply, accumulate and scale steps for the left
// channel and, in stereo, again for the right (one multiplier shared by both
// channels) before it is emitted. Reset is synchronous, active high,
// and clears the configuration to its defaults and the stream state. A stalled
// result side holds the sequencer only when the next result is ready to go.
module channel_mix_linear_resampler (
  input  logic          clk,
  input  logic          rst,
  cmlr_frame_if.sink    frames,
  cmlr_result_if.source results,
  cmlr_cfg_if.sink      cfg
);

  cmlr_pkg::cmd_t cmd;
  cmlr_pkg::sts_t sts;
  logic           in_ready;

  // Configuration writes are always taken; they must only arrive while idle, which the block does not enforce.
  assign cfg.ready    = 1'b1;
  assign frames.ready = in_ready;

  // The sequencer owns the input handshake and steps the datapath.
  cmlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frames.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the stream state and the result register, so a
  // finished result can wait while the next item is accepted.
  cmlr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .frame     (frames.data),
    .cfg_wr    (cfg.valid),
    .cfg_data  (cfg.data),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
  );

endmodule
